// ----- rtl/text_frame_line_raw_deframer_unit_assert.svh -----
// Assertion macros shared by the checker of the deframer unit.
`ifndef TEXT_FRAME_LINE_RAW_DEFRAMER_UNIT_ASSERT_SVH
`define TEXT_FRAME_LINE_RAW_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define TFRD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define TFRD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

// ----- rtl/tfrd_pkg.sv -----
// Shared types and constants of the text frame, line and raw deframer.
`default_nettype none

package tfrd_pkg;

    localparam int FRAME_LEN_DEF = 64;
    localparam int RAW_LEN_DEF   = 24;

    // All record lengths stay below 64 with the default parameters.
    localparam int LEN_W = 6;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_IDLE = 1'b1;

    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7E;

    typedef enum logic [1:0] {
        KIND_FRAME = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_RAW   = 2'd2
    } t_kind;

    typedef struct packed {
        logic             start;
        t_kind            kind;
        logic [LEN_W-1:0] len;
        logic             ovf;
    } t_rec_req;

endpackage

`default_nettype wire

// ----- rtl/text_frame_line_raw_deframer_unit.sv -----
// The sequencer registers the request of the byte that completes a record, then reads each
// beat of it in its read state and presents the beat in the output state that follows; an
// empty record skips the read state. No input item is taken while a record is read out, an
// output stall holds the beat, and items that complete no record are taken back to back.
// Reset clears the mode, the counts and the sequencer; the byte store is not cleared.
`default_nettype none

module text_frame_line_raw_deframer_unit import tfrd_pkg::*; #(
    parameter int FRAME_LEN = FRAME_LEN_DEF,
    parameter int RAW_LEN   = RAW_LEN_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_opcode,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_record_kind,
    output logic [7:0]      o_data_byte,
    output logic            o_has_data,
    output logic            o_overflowed,
    output logic            o_last_of_record
);

    localparam int DEPTH = (FRAME_LEN - 4) + (FRAME_LEN - 1) + RAW_LEN;
    localparam int AW    = $clog2(DEPTH);

    logic          accept;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;
    logic          busy;
    t_rec_req      req;

    assign o_in_ready = !busy;
    assign accept     = i_in_valid && o_in_ready;

    tfrd_parse #(
        .FRAME_LEN (FRAME_LEN),
        .RAW_LEN   (RAW_LEN),
        .AW        (AW)
    ) u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_opcode  (i_opcode),
        .i_rx_byte (i_rx_byte),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_req     (req)
    );

    tfrd_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    tfrd_rdout #(
        .FRAME_LEN (FRAME_LEN),
        .AW        (AW)
    ) u_rdout (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (req),
        .i_rdata          (rdata),
        .o_re             (re),
        .o_raddr          (raddr),
        .o_busy           (busy),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_record_kind    (o_record_kind),
        .o_data_byte      (o_data_byte),
        .o_has_data       (o_has_data),
        .o_overflowed     (o_overflowed),
        .o_last_of_record (o_last_of_record)
    );

endmodule

`default_nettype wire

// ----- rtl/tfrd_mem.sv -----
// Byte store shared by the frame, line and raw regions, one write and one read port.
`default_nettype none

module tfrd_mem #(
    parameter int DEPTH = 147,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic [7:0]         o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/tfrd_parse.sv -----
// Byte classifier: tracks the receive mode and counts, writes bytes, raises record requests.
`default_nettype none

module tfrd_parse import tfrd_pkg::*; #(
    parameter int FRAME_LEN = FRAME_LEN_DEF,
    parameter int RAW_LEN   = RAW_LEN_DEF,
    parameter int AW        = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic          i_opcode,
    input  wire logic [7:0]    i_rx_byte,
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output logic [7:0]         o_wdata,
    output t_rec_req           o_req
);

    localparam int FRAME_CAP  = FRAME_LEN - 4;
    localparam int LINE_CAP   = FRAME_LEN - 1;
    localparam int LINE_BASE  = FRAME_CAP;
    localparam int RAW_BASE   = FRAME_CAP + LINE_CAP;

    typedef enum logic [1:0] {
        MODE_WAIT  = 2'd0,
        MODE_FRAME = 2'd1,
        MODE_LINE  = 2'd2
    } t_mode;

    t_mode            r_mode, n_mode;
    logic [LEN_W-1:0] r_fcnt, n_fcnt;
    logic             r_fovf, n_fovf;
    logic [LEN_W-1:0] r_lcnt, n_lcnt;
    logic             r_lovf, n_lovf;
    logic [LEN_W-1:0] r_rcnt, n_rcnt;

    logic is_eol;
    logic is_text;

    assign is_eol  = (i_rx_byte == CH_CR) || (i_rx_byte == CH_LF);
    assign is_text = (i_rx_byte == CH_TAB) ||
                     ((i_rx_byte >= CH_PRINT_LO) && (i_rx_byte <= CH_PRINT_HI));

    always_comb begin
        n_mode  = r_mode;
        n_fcnt  = r_fcnt;
        n_fovf  = r_fovf;
        n_lcnt  = r_lcnt;
        n_lovf  = r_lovf;
        n_rcnt  = r_rcnt;
        o_we    = 1'b0;
        o_waddr = '0;
        o_wdata = i_rx_byte;
        o_req   = '{start: 1'b0, kind: KIND_FRAME, len: '0, ovf: 1'b0};

        if (i_accept) begin
            if (i_opcode == OP_IDLE) begin
                if (r_rcnt != '0) begin
                    o_req  = '{start: 1'b1, kind: KIND_RAW, len: r_rcnt, ovf: 1'b0};
                    n_rcnt = '0;
                end
            end else if (i_rx_byte == CH_DOLLAR) begin
                if (r_mode == MODE_LINE) begin
                    if ((r_lcnt != '0) || r_lovf) begin
                        o_req  = '{start: 1'b1, kind: KIND_LINE, len: r_lcnt, ovf: r_lovf};
                        n_lcnt = '0;
                        n_lovf = 1'b0;
                    end
                end else if ((r_mode == MODE_WAIT) && (r_rcnt != '0)) begin
                    o_req  = '{start: 1'b1, kind: KIND_RAW, len: r_rcnt, ovf: 1'b0};
                    n_rcnt = '0;
                end
                // A dollar always opens a fresh frame, also inside a frame.
                n_mode = MODE_FRAME;
                n_fcnt = '0;
                n_fovf = 1'b0;
            end else begin
                case (r_mode)
                    MODE_FRAME: begin
                        if (i_rx_byte == CH_HASH) begin
                            n_mode = MODE_WAIT;
                            o_req  = '{start: 1'b1, kind: KIND_FRAME, len: r_fcnt, ovf: r_fovf};
                        end else if (!r_fovf) begin
                            if (r_fcnt < LEN_W'(FRAME_CAP)) begin
                                o_we    = 1'b1;
                                o_waddr = AW'(r_fcnt);
                                n_fcnt  = r_fcnt + 1'b1;
                            end else begin
                                n_fovf = 1'b1;
                            end
                        end
                    end
                    MODE_LINE: begin
                        if (is_eol) begin
                            n_mode = MODE_WAIT;
                            if ((r_lcnt != '0) || r_lovf) begin
                                o_req  = '{start: 1'b1, kind: KIND_LINE, len: r_lcnt,
                                           ovf: r_lovf};
                                n_lcnt = '0;
                                n_lovf = 1'b0;
                            end
                        end else if (!r_lovf) begin
                            if (r_lcnt < LEN_W'(LINE_CAP)) begin
                                o_we    = 1'b1;
                                o_waddr = AW'(LINE_BASE) + AW'(r_lcnt);
                                n_lcnt  = r_lcnt + 1'b1;
                            end else begin
                                n_lovf = 1'b1;
                            end
                        end
                    end
                    default: begin
                        if (is_eol) begin
                            if ((r_lcnt != '0) || r_lovf) begin
                                o_req  = '{start: 1'b1, kind: KIND_LINE, len: r_lcnt,
                                           ovf: r_lovf};
                                n_lcnt = '0;
                                n_lovf = 1'b0;
                            end
                        end else if (is_text) begin
                            n_mode = MODE_LINE;
                            if (r_lcnt < LEN_W'(LINE_CAP)) begin
                                o_we    = 1'b1;
                                o_waddr = AW'(LINE_BASE) + AW'(r_lcnt);
                                n_lcnt  = r_lcnt + 1'b1;
                            end else begin
                                n_lovf = 1'b1;
                            end
                        end else begin
                            // The raw count never rests at the limit, the last byte flushes it.
                            o_we    = 1'b1;
                            o_waddr = AW'(RAW_BASE) + AW'(r_rcnt);
                            if (r_rcnt == LEN_W'(RAW_LEN - 1)) begin
                                o_req  = '{start: 1'b1, kind: KIND_RAW, len: LEN_W'(RAW_LEN),
                                           ovf: 1'b0};
                                n_rcnt = '0;
                            end else begin
                                n_rcnt = r_rcnt + 1'b1;
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_WAIT;
            r_fcnt <= '0;
            r_fovf <= 1'b0;
            r_lcnt <= '0;
            r_lovf <= 1'b0;
            r_rcnt <= '0;
        end else begin
            r_mode <= n_mode;
            r_fcnt <= n_fcnt;
            r_fovf <= n_fovf;
            r_lcnt <= n_lcnt;
            r_lovf <= n_lovf;
            r_rcnt <= n_rcnt;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tfrd_rdout.sv -----
// Record readout sequencer: walks a stored record through the memory and presents its beats.
`default_nettype none

module tfrd_rdout import tfrd_pkg::*; #(
    parameter int FRAME_LEN = FRAME_LEN_DEF,
    parameter int AW        = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_rec_req      i_req,
    input  wire logic [7:0]    i_rdata,
    output logic               o_re,
    output logic [AW-1:0]      o_raddr,
    output logic               o_busy,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [1:0]         o_record_kind,
    output logic [7:0]         o_data_byte,
    output logic               o_has_data,
    output logic               o_overflowed,
    output logic               o_last_of_record
);

    localparam int LINE_BASE = FRAME_LEN - 4;
    localparam int RAW_BASE  = (FRAME_LEN - 4) + (FRAME_LEN - 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_RD   = 2'd1,
        S_OUT  = 2'd2
    } t_state;

    t_state           r_state;
    t_kind            r_kind;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_k;
    logic             r_ovf;
    logic             r_empty;
    logic [AW-1:0]    base;
    logic             last;

    always_comb begin
        case (r_kind)
            KIND_FRAME: base = '0;
            KIND_LINE:  base = AW'(LINE_BASE);
            default:    base = AW'(RAW_BASE);
        endcase
    end

    assign last    = r_empty || (({1'b0, r_k} + 1'b1) == {1'b0, r_len});
    assign o_re    = (r_state == S_RD);
    assign o_raddr = base + AW'(r_k);
    assign o_busy  = (r_state != S_IDLE);

    assign o_out_valid      = (r_state == S_OUT);
    assign o_record_kind    = r_kind;
    assign o_data_byte      = r_empty ? 8'h00 : i_rdata;
    assign o_has_data       = !r_empty;
    assign o_overflowed     = r_ovf;
    assign o_last_of_record = last;

    // The parser writes a byte at the edge that accepts it, and the read state is entered at
    // that edge at the earliest, so every read of a record comes after its last write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_kind  <= i_req.kind;
                        r_len   <= i_req.len;
                        r_ovf   <= i_req.ovf;
                        r_empty <= (i_req.len == '0);
                        r_k     <= '0;
                        r_state <= (i_req.len == '0) ? S_OUT : S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        if (last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tfrd_chk.sv -----
// Port-level checker of the deframer unit, bound to the top level.
`default_nettype none
`include "text_frame_line_raw_deframer_unit_assert.svh"

module tfrd_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic       i_opcode,
    input wire logic [7:0] i_rx_byte,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] o_record_kind,
    input wire logic [7:0] o_data_byte,
    input wire logic       o_has_data,
    input wire logic       o_overflowed,
    input wire logic       o_last_of_record
);

    // Input beats are taken only while no record is being read out.
    `TFRD_ASSERT_NOW(a_no_input_during_readout, o_out_valid, !o_in_ready)
    // An empty record is a single beat.
    `TFRD_ASSERT_NOW(a_empty_is_last, o_out_valid && !o_has_data, o_last_of_record)
    `TFRD_ASSERT_NOW(a_empty_is_zero, o_out_valid && !o_has_data, o_data_byte == 8'h00)
    `TFRD_ASSERT_NOW(a_kind_legal, o_out_valid, o_record_kind != 2'd3)
    `TFRD_ASSERT_NEXT(a_stall_holds, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_data_byte) && $stable(o_last_of_record))

endmodule

bind text_frame_line_raw_deframer_unit tfrd_chk u_chk (.*);

`default_nettype wire

// ----- test/tb_text_frame_line_raw_deframer_unit.sv -----
// Self-checking testbench of the text frame, line and raw deframer unit.
module tb_text_frame_line_raw_deframer_unit;
    import tfrd_pkg::*;

    localparam int FRAME_CAP    = FRAME_LEN_DEF - 4;
    localparam int LINE_CAP     = FRAME_LEN_DEF - 1;
    localparam int RAW_CAP      = RAW_LEN_DEF;
    localparam int ITEM_TARGET  = 120;
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_OFF     = 200;
    localparam int SETTLE       = 20;

    localparam logic [1:0] RX_WAIT  = 2'd0;
    localparam logic [1:0] RX_FRAME = 2'd1;
    localparam logic [1:0] RX_LINE  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] dbyte;
        logic       has;
        logic       ovf;
        logic       last;
    } t_beat;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic       typed;
        t_beat      want;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic       i_opcode;
    logic [7:0] i_rx_byte;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [1:0] o_record_kind;
    logic [7:0] o_data_byte;
    logic       o_has_data;
    logic       o_overflowed;
    logic       o_last_of_record;

    text_frame_line_raw_deframer_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_record_kind    (o_record_kind),
        .o_data_byte      (o_data_byte),
        .o_has_data       (o_has_data),
        .o_overflowed     (o_overflowed),
        .o_last_of_record (o_last_of_record)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Shadow copy of the receiver state.
    logic [1:0] rx_mode;
    logic [7:0] frame_buf [FRAME_CAP];
    int         frame_cnt;
    logic       frame_ovf;
    logic [7:0] line_buf [LINE_CAP];
    int         line_cnt;
    logic       line_ovf;
    logic [7:0] raw_buf [RAW_CAP];
    int         raw_cnt;

    t_beat pending_beats [$];
    int    err_count;
    int    items_sent;
    int    beats_seen;
    bit    draining;

    function automatic bit is_text(input logic [7:0] b);
        return (b == CH_TAB) || (b >= CH_PRINT_LO && b <= CH_PRINT_HI);
    endfunction

    task automatic queue_record(input logic [1:0] kind, input int n, input logic ovf);
        t_beat b;
        int    k;
        b.kind = kind;
        b.ovf  = ovf;
        if (n == 0) begin
            b.dbyte = 8'h00;
            b.has   = 1'b0;
            b.last  = 1'b1;
            pending_beats.push_back(b);
        end else begin
            for (k = 0; k < n; k++) begin
                case (kind)
                    KIND_FRAME: b.dbyte = frame_buf[k];
                    KIND_LINE:  b.dbyte = line_buf[k];
                    default:    b.dbyte = raw_buf[k];
                endcase
                b.has  = 1'b1;
                b.last = (k == n - 1);
                pending_beats.push_back(b);
            end
        end
    endtask

    task automatic release_raw();
        if (raw_cnt != 0) begin
            queue_record(KIND_RAW, raw_cnt, 1'b0);
            raw_cnt = 0;
        end
    endtask

    task automatic release_line();
        if (line_cnt != 0 || line_ovf) begin
            queue_record(KIND_LINE, line_cnt, line_ovf);
            line_cnt = 0;
            line_ovf = 1'b0;
        end
    endtask

    // Advances the shadow state by one input item and queues the beats it releases.
    task automatic deframe_item(input logic op, input logic [7:0] b);
        if (op == OP_IDLE) begin
            release_raw();
        end else if (b == CH_DOLLAR) begin
            if (rx_mode == RX_LINE) begin
                release_line();
            end else if (rx_mode == RX_WAIT) begin
                release_raw();
            end
            rx_mode   = RX_FRAME;
            frame_cnt = 0;
            frame_ovf = 1'b0;
        end else if (rx_mode == RX_FRAME) begin
            if (b == CH_HASH) begin
                rx_mode = RX_WAIT;
                queue_record(KIND_FRAME, frame_cnt, frame_ovf);
            end else if (!frame_ovf) begin
                if (frame_cnt < FRAME_CAP) begin
                    frame_buf[frame_cnt] = b;
                    frame_cnt++;
                end else begin
                    frame_ovf = 1'b1;
                end
            end
        end else if (rx_mode == RX_LINE) begin
            if (b == CH_CR || b == CH_LF) begin
                rx_mode = RX_WAIT;
                release_line();
            end else if (!line_ovf) begin
                if (line_cnt < LINE_CAP) begin
                    line_buf[line_cnt] = b;
                    line_cnt++;
                end else begin
                    line_ovf = 1'b1;
                end
            end
        end else if (b == CH_CR || b == CH_LF) begin
            release_line();
        end else if (is_text(b)) begin
            rx_mode = RX_LINE;
            if (line_cnt < LINE_CAP) begin
                line_buf[line_cnt] = b;
                line_cnt++;
            end else begin
                line_ovf = 1'b1;
            end
        end else if (raw_cnt < RAW_CAP) begin
            raw_buf[raw_cnt] = b;
            raw_cnt++;
            if (raw_cnt == RAW_CAP) begin
                release_raw();
            end
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_raw();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (is_text(b) || b == CH_CR || b == CH_LF) begin
            b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    function automatic logic [7:0] pick_text();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (!is_text(b) || b == CH_DOLLAR) begin
            b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    function automatic logic [7:0] pick_body(input logic [7:0] x0, input logic [7:0] x1,
                                             input logic [7:0] x2);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == x0 || b == x1 || b == x2) begin
            b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    function automatic t_stim_row plain(input logic op, input logic [7:0] data);
        t_stim_row r;
        r       = '0;
        r.op    = op;
        r.data  = data;
        return r;
    endfunction

    function automatic t_stim_row checked(input logic op, input logic [7:0] data,
                                          input logic [1:0] kind, input logic [7:0] dbyte,
                                          input logic has);
        t_stim_row r;
        r            = plain(op, data);
        r.typed      = 1'b1;
        r.want.kind  = kind;
        r.want.dbyte = dbyte;
        r.want.has   = has;
        r.want.ovf   = 1'b0;
        r.want.last  = 1'b1;
        return r;
    endfunction

    task automatic send_item(input t_stim_row r, input bit calm);
        int gap;
        int n0;
        gap = calm ? 0 : pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= r.op;
        i_rx_byte  <= r.data;
        do @(posedge i_clk); while (!o_in_ready);
        n0 = pending_beats.size();
        deframe_item(r.op, r.data);
        // A hand-written expectation replaces the single beat computed for this row.
        if (r.typed) begin
            while (pending_beats.size() > n0) begin
                pending_beats.delete(pending_beats.size() - 1);
            end
            pending_beats.push_back(r.want);
        end
        items_sent++;
    endtask

    task automatic report(input string field, input logic [7:0] want, input logic [7:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        err_count++;
    endtask

    task automatic check_beat();
        t_beat want;
        beats_seen++;
        if (pending_beats.size() == 0) begin
            report("unexpected beat, kind", 8'h00, {6'd0, o_record_kind});
        end else begin
            want = pending_beats.pop_front();
            if (o_record_kind !== want.kind) begin
                report("record_kind", {6'd0, want.kind}, {6'd0, o_record_kind});
            end
            if (o_has_data !== want.has) begin
                report("has_data", {7'd0, want.has}, {7'd0, o_has_data});
            end
            if (o_data_byte !== want.dbyte) begin
                report("data_byte", want.dbyte, o_data_byte);
            end
            if (o_overflowed !== want.ovf) begin
                report("overflowed", {7'd0, want.ovf}, {7'd0, o_overflowed});
            end
            if (o_last_of_record !== want.last) begin
                report("last_of_record", {7'd0, want.last}, {7'd0, o_last_of_record});
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            check_beat();
        end
    end

    // Output side: random stalls, calm stretches, and one long hold-off that backs the
    // block up while the input side keeps offering items.
    initial begin : out_side
        int stall_left;
        int cyc;
        bit calm_out;
        bit hold_done;
        stall_left  = 0;
        cyc         = 0;
        calm_out    = 1'b0;
        hold_done   = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 128 == 0) begin
                calm_out = ($urandom_range(0, 3) == 0);
            end
            if (!hold_done && beats_seen >= 40) begin
                stall_left = HOLD_OFF;
                hold_done  = 1'b1;
            end
            if (draining) begin
                i_out_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!calm_out) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("text_frame_line_raw_deframer_unit test failed");
        $finish;
    end

    initial begin : stimulus
        t_stim_row rows [$];
        t_stim_row seq [$];
        int        pick;
        int        len;
        int        seq_no;
        bit        calm;
        bit        stretch;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_opcode   = OP_BYTE;
        i_rx_byte  = 8'h00;
        draining   = 1'b0;
        err_count  = 0;
        items_sent = 0;
        beats_seen = 0;
        rx_mode    = RX_WAIT;
        frame_cnt  = 0;
        frame_ovf  = 1'b0;
        line_cnt   = 0;
        line_ovf   = 1'b0;
        raw_cnt    = 0;

        rows.push_back(plain(OP_IDLE, 8'hA5));
        rows.push_back(plain(OP_BYTE, CH_DOLLAR));
        rows.push_back(checked(OP_BYTE, CH_HASH, KIND_FRAME, 8'h00, 1'b0));
        rows.push_back(plain(OP_BYTE, CH_CR));
        rows.push_back(plain(OP_BYTE, 8'h00));
        rows.push_back(plain(OP_BYTE, 8'hFF));
        rows.push_back(plain(OP_IDLE, 8'h5A));
        rows.push_back(plain(OP_BYTE, 8'h80));
        rows.push_back(checked(OP_BYTE, CH_DOLLAR, KIND_RAW, 8'h80, 1'b1));
        rows.push_back(plain(OP_BYTE, 8'h00));
        rows.push_back(plain(OP_BYTE, CH_DOLLAR));
        rows.push_back(plain(OP_BYTE, 8'h41));
        rows.push_back(plain(OP_BYTE, CH_CR));
        rows.push_back(plain(OP_BYTE, CH_HASH));
        rows.push_back(plain(OP_BYTE, CH_TAB));
        rows.push_back(plain(OP_BYTE, CH_PRINT_HI));
        rows.push_back(plain(OP_BYTE, CH_PRINT_LO));
        rows.push_back(plain(OP_BYTE, CH_HASH));
        rows.push_back(plain(OP_BYTE, 8'h1F));
        rows.push_back(plain(OP_BYTE, CH_LF));
        rows.push_back(plain(OP_BYTE, 8'h7A));
        rows.push_back(plain(OP_BYTE, CH_DOLLAR));
        rows.push_back(checked(OP_BYTE, CH_HASH, KIND_FRAME, 8'h00, 1'b0));
        rows.push_back(plain(OP_BYTE, 8'h7F));
        rows.push_back(plain(OP_BYTE, CH_LF));
        rows.push_back(checked(OP_IDLE, 8'hC3, KIND_RAW, 8'h7F, 1'b1));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) begin
            send_item(rows[k], 1'b0);
        end

        // The first two sequences fill a frame past capacity and a raw run to its limit.
        seq_no = 0;
        while (items_sent < ITEM_TARGET) begin
            seq.delete();
            calm    = ($urandom_range(0, 3) == 0);
            stretch = (seq_no < 2);
            pick    = stretch ? seq_no * 6 : $urandom_range(0, 9);
            case (pick)
                0, 1, 2: begin
                    len = stretch ? $urandom_range(FRAME_CAP + 1, FRAME_CAP + 2)
                                  : $urandom_range(0, 10);
                    seq.push_back(plain(OP_BYTE, CH_DOLLAR));
                    repeat (len) begin
                        seq.push_back(plain(OP_BYTE, pick_body(CH_DOLLAR, CH_HASH, CH_HASH)));
                    end
                    seq.push_back(plain(OP_BYTE, CH_HASH));
                end
                3, 4, 5: begin
                    len = stretch ? $urandom_range(LINE_CAP, LINE_CAP + 4)
                                  : $urandom_range(0, 10);
                    seq.push_back(plain(OP_BYTE, pick_text()));
                    repeat (len) begin
                        seq.push_back(plain(OP_BYTE, pick_body(CH_DOLLAR, CH_CR, CH_LF)));
                    end
                    seq.push_back(plain(OP_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF));
                end
                6, 7: begin
                    len = stretch ? $urandom_range(RAW_CAP, RAW_CAP + 2)
                                  : $urandom_range(1, 6);
                    repeat (len) begin
                        seq.push_back(plain(OP_BYTE, pick_raw()));
                    end
                    if ($urandom_range(0, 1) == 1) begin
                        seq.push_back(plain(OP_IDLE, 8'($urandom_range(0, 255))));
                    end
                end
                8: begin
                    seq.push_back(plain(OP_IDLE, 8'($urandom_range(0, 255))));
                end
                default: begin
                    repeat ($urandom_range(1, 4)) begin
                        seq.push_back(plain(1'($urandom_range(0, 1)),
                                            8'($urandom_range(0, 255))));
                    end
                end
            endcase
            foreach (seq[k]) begin
                send_item(seq[k], calm);
            end
            seq_no++;
        end

        i_in_valid <= 1'b0;
        draining = 1'b1;
        while (pending_beats.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);

        if (err_count == 0) begin
            $display("text_frame_line_raw_deframer_unit test passed");
        end else begin
            $display("text_frame_line_raw_deframer_unit test failed");
        end
        $finish;
    end

endmodule
